@@ sv/csb_pkg.sv @@
// ----------------------------------------------------------------------------
// csb_pkg
// Types and constants shared by the capture split boundary block.
// ----------------------------------------------------------------------------
package csb_pkg;

  // Largest capture length that is still kept.
  localparam int unsigned MAX_CAPTURE = 131072;

  localparam logic [29:0] NS_PER_SEC       = 30'd1000000000;
  localparam logic [29:0] US_TO_NS         = 30'd1000;
  localparam logic [29:0] NS_TO_NS         = 30'd1;
  localparam logic [4:0]  RECORD_HDR_BYTES = 5'd16;
  localparam logic [62:0] TARGET_TIME_RST  = 63'd1000000000;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIV_CNT_W  = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPLIT_BY_TIME     = 3'd0,
    REG_TARGET_BYTES      = 3'd1,
    REG_TARGET_TIME_NS    = 3'd2,
    REG_TRIM_BYTES        = 3'd3,
    REG_FRACTION_IN_MICRO = 3'd4
  } csb_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_FRAC,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } csb_state_e;

  typedef struct packed {
    logic        split_by_time;
    logic [47:0] target_bytes;
    logic [62:0] target_time_ns;
    logic [7:0]  trim_bytes;
    logic        fraction_in_micro;
  } csb_cfg_t;

  typedef struct packed {
    logic [31:0] ts_seconds;
    logic [29:0] ts_fraction;
    logic [17:0] capture_length;
    logic [17:0] wire_length;
  } csb_in_t;

  typedef struct packed {
    logic        length_error;
    logic        new_split;
    logic [63:0] stamp_ns;
    logic [63:0] name_time_ns;
    logic [63:0] name_start_ns;
    logic [17:0] out_capture_length;
    logic [17:0] out_wire_length;
  } csb_out_t;

endpackage

@@ sv/capture_split_boundary.sv @@
// ----------------------------------------------------------------------------
// capture_split_boundary
// Per-record timestamp, length trim and output file split decision.
// ----------------------------------------------------------------------------
// One record header is taken at a time; the next one waits until the last
// has left the DONE state. The shared 32x30 multiplier makes two passes
// (seconds times 1e9, then the fraction times 1000 or 1), the DECIDE state
// decides and the DONE state hands the result to the output register. A
// time-mode split also runs the bit-serial window rounding divider. A record
// with an out-of-range capture length goes straight to DONE with only
// length_error set. The output register lets the next record enter while
// a result still waits under out_stall_i. cfg_ready_o is always high.
module capture_split_boundary
  import csb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  csb_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csb_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  csb_cfg_t   cfg;
  csb_state_e state_q, state_d;
  csb_in_t    in_q, in_d;
  csb_out_t   res_q, res_d;
  csb_out_t   out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic [63:0] ts_q, ts_d;
  logic [63:0] fbc_q, fbc_d;
  logic [63:0] win_q, win_d;
  logic [63:0] prev_q, prev_d;
  logic [63:0] num_q, num_d;

  logic [31:0] mul_a;
  logic [29:0] mul_b;
  logic [61:0] mul_p;

  logic        div_start;
  logic        div_done;
  logic [62:0] div_rem;

  logic [62:0] t_win;
  logic [63:0] diff;
  logic [63:0] prev_eff;
  logic [17:0] trim_cap;
  logic [17:0] trim_wire;
  logic [63:0] new_win;
  logic        len_bad;

  csb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  csb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_d),
    .den_i   (t_win),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // shared multiplier
  always_comb begin
    if (state_q == ST_SEC) begin
      mul_a = in_q.ts_seconds;
      mul_b = NS_PER_SEC;
    end else begin
      mul_a = {2'b00, in_q.ts_fraction};
      mul_b = cfg.fraction_in_micro ? US_TO_NS : NS_TO_NS;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign len_bad   = (in_q.capture_length == '0) ||
                     (in_q.capture_length > 18'(MAX_CAPTURE));
  assign trim_cap  = (in_q.capture_length > {10'd0, cfg.trim_bytes}) ?
                     (in_q.capture_length - {10'd0, cfg.trim_bytes}) : '0;
  assign trim_wire = (in_q.wire_length > {10'd0, cfg.trim_bytes}) ?
                     (in_q.wire_length - {10'd0, cfg.trim_bytes}) : '0;
  assign t_win     = (cfg.target_time_ns == '0) ? 63'd1 : cfg.target_time_ns;
  assign diff      = ts_q - win_q;
  assign prev_eff  = (prev_q == '0) ? ts_q : prev_q;
  // quotient times divisor is the dividend less the remainder
  assign new_win   = num_q - {1'b0, div_rem};

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ts_d        = ts_q;
    fbc_d       = fbc_q;
    win_d       = win_q;
    prev_d      = prev_q;
    num_d       = num_q;
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          state_d = ST_SEC;
        end
      end
      ST_SEC: begin
        ts_d  = {2'b00, mul_p};
        res_d = '0;
        if (len_bad) begin
          res_d.length_error = 1'b1;
          state_d            = ST_DONE;
        end else begin
          state_d = ST_FRAC;
        end
      end
      ST_FRAC: begin
        ts_d    = ts_q + {2'b00, mul_p};
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_d.stamp_ns           = ts_q;
        res_d.out_capture_length = trim_cap;
        res_d.out_wire_length    = trim_wire;
        prev_d                   = prev_eff;
        fbc_d = fbc_q + 64'(RECORD_HDR_BYTES) + {46'd0, trim_cap};
        state_d = ST_DONE;
        if (!cfg.split_by_time) begin
          if (fbc_q > {16'd0, cfg.target_bytes}) begin
            res_d.new_split     = 1'b1;
            res_d.name_time_ns  = ts_q;
            res_d.name_start_ns = prev_eff;
            prev_d              = ts_q;
            fbc_d = 64'(RECORD_HDR_BYTES) + {46'd0, trim_cap};
          end
        end else if (!diff[63] && (diff > {1'b0, t_win})) begin
          // window rounding: (ts + t/4) / t * t
          num_d     = ts_q + {3'b000, t_win[62:2]};
          div_start = 1'b1;
          fbc_d     = fbc_q;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d.new_split     = 1'b1;
          res_d.name_time_ns  = new_win + {1'b0, t_win};
          res_d.name_start_ns = new_win;
          prev_d              = win_q;
          win_d               = new_win;
          fbc_d = 64'(RECORD_HDR_BYTES) + {46'd0, res_q.out_capture_length};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      fbc_q       <= '1;
      win_q       <= '0;
      prev_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      fbc_q       <= fbc_d;
      win_q       <= win_d;
      prev_q      <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    out_q <= out_d;
    ts_q  <= ts_d;
    num_q <= num_d;
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_SEC)
    else $error("record transfer did not start the sequence");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the rounding state");

  a_error_no_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.length_error |->
      !out_data_o.new_split && out_data_o.stamp_ns == '0)
    else $error("dropped record carries a result");

  a_no_split_names: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.new_split |->
      out_data_o.name_time_ns == '0 && out_data_o.name_start_ns == '0)
    else $error("name timestamps set without a split");

endmodule

@@ sv/csb_cfg.sv @@
// ----------------------------------------------------------------------------
// csb_cfg
// Configuration register file, one write per transfer.
// ----------------------------------------------------------------------------
module csb_cfg
  import csb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output csb_cfg_t              cfg_o
);

  csb_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (csb_reg_e'(cfg_index_i))
        REG_SPLIT_BY_TIME:     cfg_d.split_by_time     = cfg_data_i[0];
        REG_TARGET_BYTES:      cfg_d.target_bytes      = cfg_data_i[47:0];
        REG_TARGET_TIME_NS:    cfg_d.target_time_ns    = cfg_data_i[62:0];
        REG_TRIM_BYTES:        cfg_d.trim_bytes        = cfg_data_i[7:0];
        REG_FRACTION_IN_MICRO: cfg_d.fraction_in_micro = cfg_data_i[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.split_by_time     <= 1'b0;
      cfg_q.target_bytes      <= '0;
      cfg_q.target_time_ns    <= TARGET_TIME_RST;
      cfg_q.trim_bytes        <= '0;
      cfg_q.fraction_in_micro <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/csb_div.sv @@
// ----------------------------------------------------------------------------
// csb_div
// Bit-serial restoring divider, remainder only, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module csb_div
  import csb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [62:0] den_i,
  output logic        done_o,
  output logic [62:0] rem_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [63:0]          num_q, num_d;
  logic [62:0]          den_q, den_d;
  logic [62:0]          rem_q, rem_d;
  logic [63:0]          shifted;

  assign shifted = {rem_q, num_q[63]};
  assign done_o  = done_q;
  assign rem_o   = rem_q;

  always_comb begin
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = DIV_STEPS;
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      num_d  = {num_q[62:0], 1'b0};
      done_d = (cnt_q == DIV_CNT_W'(1));
      // shifted stays below twice the divisor, so the result fits 63 bits
      if (shifted >= {1'b0, den_q}) begin
        rem_d = 63'(shifted - {1'b0, den_q});
      end else begin
        rem_d = shifted[62:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

endmodule
